// File: design/itac_pkg.sv
// ----------------------------------------------------------------------------
// itac_pkg
// Shared types, constants and helpers of the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itac_pkg;

  localparam int unsigned BinWidth  = 64;  // width of the value to convert
  localparam int unsigned NumCells  = 20;  // digit cells: 2^64 needs 20 decimal digits
  localparam int unsigned DigWidth  = 4;   // one BCD or hex digit per cell
  localparam int unsigned CharWidth = 7;

  localparam logic [1:0] ModeSigned   = 2'd0;
  localparam logic [1:0] ModeUnsigned = 2'd1;
  localparam logic [1:0] ModeHex      = 2'd2;

  localparam logic [CharWidth-1:0] CharMinus = 7'h2d;
  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharLowA  = 7'h61;

  // input word
  typedef struct packed {
    logic [1:0]          mode;
    logic [BinWidth-1:0] value;
  } in_t;

  // output word
  typedef struct packed {
    logic [CharWidth-1:0] ascii_char;
    logic                 last_char;
  } out_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic clear;        // zero the digit
    logic shift_bit;    // take one binary bit from below (with add-3 in decimal)
    logic shift_digit;  // take the whole digit from below
    logic dec;          // decimal correction on
  } cell_ctrl_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [DigWidth-1:0] dig);
    logic [CharWidth-1:0] res;
    if (dig < 4'd10) begin
      res = CharZero + CharWidth'(dig);
    end else begin
      res = CharLowA + CharWidth'(dig - 4'd10);
    end
    return res;
  endfunction

endpackage

// File: design/itac_cell.sv
// ----------------------------------------------------------------------------
// itac_cell
// One digit of the conversion chain: add-3 and shift, or pass the digit on.
// ----------------------------------------------------------------------------
module itac_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itac_pkg::cell_ctrl_t              ctrl_i,
  input  logic                              bit_i,
  input  logic [itac_pkg::DigWidth-1:0]     digit_i,
  output logic                              bit_o,
  output logic [itac_pkg::DigWidth-1:0]     digit_o
);
  import itac_pkg::*;

  logic [DigWidth-1:0] dig_q, dig_d;
  logic [DigWidth-1:0] adj;

  // in decimal mode, correct before the shift so the digit never passes nine
  always_comb begin
    adj = dig_q;
    if (ctrl_i.dec && (dig_q >= 4'd5)) begin
      adj = dig_q + 4'd3;
    end
  end

  always_comb begin
    dig_d = dig_q;
    if (ctrl_i.clear) begin
      dig_d = '0;
    end else if (ctrl_i.shift_bit) begin
      dig_d = {adj[DigWidth-2:0], bit_i};
    end else if (ctrl_i.shift_digit) begin
      dig_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= '0;
    end else begin
      dig_q <= dig_d;
    end
  end

  assign bit_o   = adj[DigWidth-1];
  assign digit_o = dig_q;

endmodule

// File: design/integer_to_ascii_converter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_converter
// Turns a 64-bit value into ASCII text in signed decimal, unsigned decimal
// or lowercase hex, one character per output word, most significant first.
// ----------------------------------------------------------------------------
// Use: drive data_i and raise start; the word is taken at a clock edge where
// start is high and busy is low. busy then stays high until the last
// character has been issued. Characters leave on result_o, each valid for
// exactly one cycle with result_valid_o high; the receiver cannot stall, so
// it must take every character in the cycle it is shown. last_char marks the
// final character; no terminator follows.
// Operation: the input bits are shifted, one input bit per cycle, through a
// row of 20 digit cells, with add-3 correction in the decimal modes; then
// the minus sign is issued when there is one; then the digits are shifted
// out of the top cell, leading zeros being dropped silently. busy stays high
// through the bit-serial conversion and the digit-serial read-out of the
// chain. The next word may be started in the cycle the last character is
// shown; a new word is not taken while one is still being converted.
// Reset: asynchronous, active low; returns to idle and drops any conversion
// in flight. Nothing is kept from one word to the next.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  itac_pkg::in_t  data_i,
  output itac_pkg::out_t result_o,
  output logic           result_valid_o
);
  import itac_pkg::*;

  localparam int unsigned CntWidth = $clog2(BinWidth);
  localparam int unsigned IdxWidth = $clog2(NumCells);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(BinWidth - 1);
  localparam logic [IdxWidth-1:0] IdxTop  = IdxWidth'(NumCells - 1);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSign,
    StEmit
  } state_e;

  state_e               state_q;
  logic [BinWidth-1:0]  bin_q;
  logic [CntWidth-1:0]  cnt_q;
  logic [IdxWidth-1:0]  idx_q;
  logic                 neg_q;
  logic                 dec_q;
  logic                 started_q;
  out_t                 result_q;
  logic                 valid_q;

  logic                 accept;
  logic                 in_neg;
  cell_ctrl_t           ctrl;
  logic [NumCells:0]    bit_chain;
  logic [DigWidth-1:0]  dig_chain [NumCells+1];
  logic [DigWidth-1:0]  top_dig;
  logic                 show_dig;

  assign accept = start && (state_q == StIdle);
  assign in_neg = (data_i.mode == ModeSigned) && data_i.value[BinWidth-1];

  // one control word drives every cell
  always_comb begin
    ctrl.clear       = accept;
    ctrl.shift_bit   = (state_q == StConv);
    ctrl.shift_digit = (state_q == StEmit);
    ctrl.dec         = dec_q;
  end

  // feed the binary value in at the bottom, read digits out at the top
  assign bit_chain[0] = bin_q[BinWidth-1];
  assign dig_chain[0] = '0;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    itac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (bit_chain[g]),
      .digit_i (dig_chain[g]),
      .bit_o   (bit_chain[g+1]),
      .digit_o (dig_chain[g+1])
    );
  end

  assign top_dig = dig_chain[NumCells];
  // drop leading zeros, but always show the units digit
  assign show_dig = started_q || (top_dig != '0) || (idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bin_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      neg_q     <= 1'b0;
      dec_q     <= 1'b0;
      started_q <= 1'b0;
      result_q  <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            // take the magnitude; the most negative value wraps to 2^63
            bin_q   <= in_neg ? (BinWidth'(0) - data_i.value) : data_i.value;
            neg_q   <= in_neg;
            dec_q   <= (data_i.mode != ModeHex);
            cnt_q   <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          bin_q <= {bin_q[BinWidth-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            idx_q     <= IdxTop;
            started_q <= 1'b0;
            state_q   <= neg_q ? StSign : StEmit;
          end
        end
        StSign: begin
          result_q.ascii_char <= CharMinus;
          result_q.last_char  <= 1'b0;
          valid_q             <= 1'b1;
          state_q             <= StEmit;
        end
        StEmit: begin
          if (show_dig) begin
            result_q.ascii_char <= digit_char(top_dig);
            result_q.last_char  <= (idx_q == '0);
            valid_q             <= 1'b1;
            started_q           <= 1'b1;
          end
          if (idx_q == '0) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule
